@@ rtl/core/char_lcd_nibble_sequencer_defines.svh @@
// Assertion macros for the character LCD nibble sequencer.
`ifndef CHAR_LCD_NIBBLE_SEQUENCER_DEFINES_SVH
`define CHAR_LCD_NIBBLE_SEQUENCER_DEFINES_SVH

`ifndef SYNTH

`define LCDNS_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("lcdns assertion failed");

`define LCDNS_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lcdns implication failed");

`define LCDNS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lcdns next-cycle check failed");

`else

`define LCDNS_ASSERT(label, clk, rst, prop)
`define LCDNS_ASSERT_IMPL(label, clk, rst, ante, cons)
`define LCDNS_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

@@ rtl/core/lcdns_pkg.sv @@
`timescale 1ns / 1ps

package lcdns_pkg;

   localparam logic [7:0] ROW1_BASE     = 8'h80;
   localparam logic [7:0] ROW2_BASE     = 8'hC0;
   localparam logic [7:0] BYTE_CLEAR    = 8'h01;
   localparam logic [7:0] BYTE_FUNC_SET = 8'h28;
   localparam logic [7:0] BYTE_DISP_ON  = 8'h0C;
   localparam logic [7:0] BYTE_ENTRY    = 8'h06;
   localparam logic [3:0] NIB_WAKE      = 4'h3;
   localparam logic [3:0] NIB_FOUR_BIT  = 4'h2;
   localparam logic [3:0] NIB_MASK      = 4'hF;

   localparam logic [1:0] ROW_ONE = 2'd1;
   localparam logic [1:0] ROW_TWO = 2'd2;

   localparam logic [1:0] WAKE_LAST      = 2'd3;
   localparam logic [1:0] INIT_BYTE_LAST = 2'd3;

   localparam logic [15:0] HOLD_US_POWER      = 16'd50000;
   localparam logic [15:0] HOLD_US_PULSE      = 16'd50;
   localparam logic [15:0] HOLD_US_SETUP      = 16'd5;
   localparam logic [15:0] HOLD_US_WAKE_LONG  = 16'd4050;
   localparam logic [15:0] HOLD_US_WAKE_SHORT = 16'd150;
   localparam logic [15:0] HOLD_US_CLEAR      = 16'd2050;

   typedef enum logic [1:0] {
      OP_INIT   = 2'd0,
      OP_WRITE  = 2'd1,
      OP_CLEAR  = 2'd2,
      OP_CURSOR = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_POWER,
      ST_WAKE,
      ST_BYTE_SEL,
      ST_BYTE_NIB
   } state_type;

   typedef enum logic [1:0] {
      STEP_POWER,
      STEP_SELECT,
      STEP_STROBE_HI,
      STEP_STROBE_LO
   } step_kind_type;

   typedef enum logic [1:0] {
      NIB_SRC_WAKE,
      NIB_SRC_FOUR_BIT,
      NIB_SRC_HIGH,
      NIB_SRC_LOW
   } nib_src_type;

   typedef enum logic [2:0] {
      HOLD_POWER,
      HOLD_PULSE,
      HOLD_SETUP,
      HOLD_WAKE_LONG,
      HOLD_WAKE_SHORT,
      HOLD_CLEAR
   } hold_code_type;

   typedef struct packed {
      logic          capture;
      logic          fire;
      step_kind_type kind;
      nib_src_type   nib_src;
      logic          rs;
      hold_code_type hold;
      logic          last;
      logic          load_init;
      logic [1:0]    init_idx;
   } ctrl_cmd_type;

   typedef struct packed {
      logic slot_free;
   } dp_status_type;

   function automatic logic [7:0] init_byte(input logic [1:0] idx);
      logic [7:0] value;
      case (idx)
         2'd0:    value = BYTE_CLEAR;
         2'd1:    value = BYTE_FUNC_SET;
         2'd2:    value = BYTE_DISP_ON;
         default: value = BYTE_ENTRY;
      endcase
      return value;
   endfunction

   function automatic logic [15:0] hold_value(input hold_code_type code);
      logic [15:0] value;
      case (code)
         HOLD_POWER:      value = HOLD_US_POWER;
         HOLD_PULSE:      value = HOLD_US_PULSE;
         HOLD_SETUP:      value = HOLD_US_SETUP;
         HOLD_WAKE_LONG:  value = HOLD_US_WAKE_LONG;
         HOLD_WAKE_SHORT: value = HOLD_US_WAKE_SHORT;
         HOLD_CLEAR:      value = HOLD_US_CLEAR;
         default:         value = HOLD_US_PULSE;
      endcase
      return value;
   endfunction

endpackage

@@ rtl/core/lcdns_ctrl.sv @@
`timescale 1ns / 1ps

module lcdns_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic [1:0]             req_op,
   output logic                   req_ready,
   input  lcdns_pkg::dp_status_type status,
   output lcdns_pkg::ctrl_cmd_type  cmd
);

   lcdns_pkg::state_type state_ff, state_in;
   lcdns_pkg::op_type    op_ff, op_in;
   logic [1:0]           cnt_ff, cnt_in;
   logic                 phase_ff, phase_in;
   logic                 half_ff, half_in;

   logic accept;
   logic free;
   logic final_nib;
   logic more_init;

   assign req_ready = (state_ff == lcdns_pkg::ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign free      = status.slot_free;
   assign final_nib = half_ff && phase_ff;
   assign more_init = (op_ff == lcdns_pkg::OP_INIT) && (cnt_ff != lcdns_pkg::INIT_BYTE_LAST);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lcdns_pkg::ST_IDLE;
         op_ff    <= lcdns_pkg::OP_INIT;
         cnt_ff   <= 2'd0;
         phase_ff <= 1'b0;
         half_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
         cnt_ff   <= cnt_in;
         phase_ff <= phase_in;
         half_ff  <= half_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      cnt_in   = cnt_ff;
      phase_in = phase_ff;
      half_in  = half_ff;
      case (state_ff)
         lcdns_pkg::ST_IDLE: begin
            if (accept) begin
               op_in    = lcdns_pkg::op_type'(req_op);
               cnt_in   = 2'd0;
               phase_in = 1'b0;
               half_in  = 1'b0;
               if (lcdns_pkg::op_type'(req_op) == lcdns_pkg::OP_INIT) begin
                  state_in = lcdns_pkg::ST_POWER;
               end else begin
                  state_in = lcdns_pkg::ST_BYTE_SEL;
               end
            end
         end
         lcdns_pkg::ST_POWER: begin
            if (free) begin
               state_in = lcdns_pkg::ST_WAKE;
               cnt_in   = 2'd0;
               phase_in = 1'b0;
            end
         end
         lcdns_pkg::ST_WAKE: begin
            if (free) begin
               phase_in = !phase_ff;
               if (phase_ff) begin
                  if (cnt_ff == lcdns_pkg::WAKE_LAST) begin
                     state_in = lcdns_pkg::ST_BYTE_SEL;
                     cnt_in   = 2'd0;
                  end else begin
                     cnt_in = cnt_ff + 2'd1;
                  end
               end
            end
         end
         lcdns_pkg::ST_BYTE_SEL: begin
            if (free) begin
               state_in = lcdns_pkg::ST_BYTE_NIB;
               phase_in = 1'b0;
               half_in  = 1'b0;
            end
         end
         lcdns_pkg::ST_BYTE_NIB: begin
            if (free) begin
               phase_in = !phase_ff;
               if (phase_ff) begin
                  half_in = !half_ff;
               end
               if (final_nib) begin
                  if (more_init) begin
                     state_in = lcdns_pkg::ST_BYTE_SEL;
                     cnt_in   = cnt_ff + 2'd1;
                  end else begin
                     state_in = lcdns_pkg::ST_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = lcdns_pkg::ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      cmd           = '0;
      cmd.capture   = accept;
      cmd.kind      = lcdns_pkg::STEP_POWER;
      cmd.nib_src   = lcdns_pkg::NIB_SRC_WAKE;
      cmd.hold      = lcdns_pkg::HOLD_PULSE;
      case (state_ff)
         lcdns_pkg::ST_IDLE: begin
            cmd.fire = 1'b0;
         end
         lcdns_pkg::ST_POWER: begin
            cmd.fire = free;
            cmd.kind = lcdns_pkg::STEP_POWER;
            cmd.hold = lcdns_pkg::HOLD_POWER;
         end
         lcdns_pkg::ST_WAKE: begin
            cmd.fire = free;
            cmd.kind = phase_ff ? lcdns_pkg::STEP_STROBE_LO : lcdns_pkg::STEP_STROBE_HI;
            cmd.nib_src = (cnt_ff == lcdns_pkg::WAKE_LAST) ? lcdns_pkg::NIB_SRC_FOUR_BIT
                                                          : lcdns_pkg::NIB_SRC_WAKE;
            if (phase_ff && (cnt_ff == 2'd0)) begin
               cmd.hold = lcdns_pkg::HOLD_WAKE_LONG;
            end else if (phase_ff && (cnt_ff == 2'd1)) begin
               cmd.hold = lcdns_pkg::HOLD_WAKE_SHORT;
            end else begin
               cmd.hold = lcdns_pkg::HOLD_PULSE;
            end
            cmd.load_init = free && phase_ff && (cnt_ff == lcdns_pkg::WAKE_LAST);
            cmd.init_idx  = 2'd0;
         end
         lcdns_pkg::ST_BYTE_SEL: begin
            cmd.fire = free;
            cmd.kind = lcdns_pkg::STEP_SELECT;
            cmd.rs   = (op_ff == lcdns_pkg::OP_WRITE);
            cmd.hold = lcdns_pkg::HOLD_SETUP;
         end
         lcdns_pkg::ST_BYTE_NIB: begin
            cmd.fire    = free;
            cmd.kind    = phase_ff ? lcdns_pkg::STEP_STROBE_LO : lcdns_pkg::STEP_STROBE_HI;
            cmd.nib_src = half_ff ? lcdns_pkg::NIB_SRC_LOW : lcdns_pkg::NIB_SRC_HIGH;
            if (final_nib && ((op_ff == lcdns_pkg::OP_CLEAR) ||
                              ((op_ff == lcdns_pkg::OP_INIT) && (cnt_ff == 2'd0)))) begin
               cmd.hold = lcdns_pkg::HOLD_CLEAR;
            end else begin
               cmd.hold = lcdns_pkg::HOLD_PULSE;
            end
            cmd.last      = final_nib && !more_init;
            cmd.load_init = free && final_nib && more_init;
            cmd.init_idx  = cnt_ff + 2'd1;
         end
         default: begin
            cmd.fire = 1'b0;
         end
      endcase
   end

endmodule

@@ rtl/core/lcdns_dp.sv @@
`timescale 1ns / 1ps

module lcdns_dp (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [1:0]              req_op,
   input  logic [7:0]              req_char_code,
   input  logic [1:0]              req_row,
   input  logic [7:0]              req_col,
   input  lcdns_pkg::ctrl_cmd_type cmd,
   output lcdns_pkg::dp_status_type status,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic                    rsp_enable_pin,
   output logic                    rsp_select_pin,
   output logic [3:0]              rsp_data_pins,
   output logic [15:0]             rsp_hold_us,
   output logic                    rsp_last
);

   logic        en_ff, en_in;
   logic        sel_ff, sel_in;
   logic [3:0]  data_ff, data_in;
   logic        valid_ff, valid_in;
   logic [7:0]  byte_ff, byte_in;
   logic [15:0] hold_ff, hold_in;
   logic        last_ff, last_in;

   logic [7:0]  row_base;
   logic [7:0]  cursor_addr;
   logic [3:0]  nib;

   always_comb begin
      case (req_row)
         lcdns_pkg::ROW_ONE: row_base = lcdns_pkg::ROW1_BASE;
         lcdns_pkg::ROW_TWO: row_base = lcdns_pkg::ROW2_BASE;
         default:            row_base = 8'h00;
      endcase
   end

   assign cursor_addr = row_base + req_col;

   always_comb begin
      byte_in = byte_ff;
      if (cmd.capture) begin
         case (lcdns_pkg::op_type'(req_op))
            lcdns_pkg::OP_WRITE:  byte_in = req_char_code;
            lcdns_pkg::OP_CLEAR:  byte_in = lcdns_pkg::BYTE_CLEAR;
            lcdns_pkg::OP_CURSOR: byte_in = cursor_addr;
            default:              byte_in = byte_ff;
         endcase
      end else if (cmd.load_init) begin
         byte_in = lcdns_pkg::init_byte(cmd.init_idx);
      end
   end

   always_comb begin
      case (cmd.nib_src)
         lcdns_pkg::NIB_SRC_WAKE:     nib = lcdns_pkg::NIB_WAKE;
         lcdns_pkg::NIB_SRC_FOUR_BIT: nib = lcdns_pkg::NIB_FOUR_BIT;
         lcdns_pkg::NIB_SRC_HIGH:     nib = byte_ff[7:4];
         lcdns_pkg::NIB_SRC_LOW:      nib = byte_ff[3:0] & lcdns_pkg::NIB_MASK;
         default:                     nib = lcdns_pkg::NIB_WAKE;
      endcase
   end

   // pin state; the result word shows the state each step leaves
   always_comb begin
      en_in   = en_ff;
      sel_in  = sel_ff;
      data_in = data_ff;
      hold_in = hold_ff;
      last_in = last_ff;
      if (cmd.fire) begin
         hold_in = lcdns_pkg::hold_value(cmd.hold);
         last_in = cmd.last;
         case (cmd.kind)
            lcdns_pkg::STEP_POWER: begin
               en_in   = 1'b0;
               data_in = 4'h0;
            end
            lcdns_pkg::STEP_SELECT: begin
               sel_in = cmd.rs;
            end
            lcdns_pkg::STEP_STROBE_HI: begin
               en_in   = 1'b1;
               data_in = nib;
            end
            lcdns_pkg::STEP_STROBE_LO: begin
               en_in = 1'b0;
            end
            default: begin
               en_in = en_ff;
            end
         endcase
      end
   end

   always_comb begin
      if (cmd.fire) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         en_ff    <= 1'b0;
         sel_ff   <= 1'b0;
         data_ff  <= 4'h0;
         valid_ff <= 1'b0;
      end else begin
         en_ff    <= en_in;
         sel_ff   <= sel_in;
         data_ff  <= data_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      hold_ff <= hold_in;
      last_ff <= last_in;
   end

   assign status.slot_free = !valid_ff || rsp_ready;

   assign rsp_valid      = valid_ff;
   assign rsp_enable_pin = en_ff;
   assign rsp_select_pin = sel_ff;
   assign rsp_data_pins  = data_ff;
   assign rsp_hold_us    = hold_ff;
   assign rsp_last       = last_ff;

endmodule

@@ rtl/core/char_lcd_nibble_sequencer.sv @@
// channel | direction | words per command
// req_    | in        | one: op, char_code, row, col
// rsp_    | out       | 5 for write/clear/cursor, 29 for init; last marks the end
//
// One pin step is issued per cycle while the result register is free.
// A new command is taken only after the final step of the previous one is issued.
// Reset is synchronous, active high; it clears the controller and the pin levels.
// A stalled rsp_ready holds the sequencer on the current step.
`timescale 1ns / 1ps
`include "char_lcd_nibble_sequencer_defines.svh"

module char_lcd_nibble_sequencer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_op,
   input  logic [7:0]  req_char_code,
   input  logic [1:0]  req_row,
   input  logic [7:0]  req_col,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_enable_pin,
   output logic        rsp_select_pin,
   output logic [3:0]  rsp_data_pins,
   output logic [15:0] rsp_hold_us,
   output logic        rsp_last
);

   lcdns_pkg::ctrl_cmd_type  cmd;
   lcdns_pkg::dp_status_type status;

   lcdns_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_op),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   lcdns_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .req_op         (req_op),
      .req_char_code  (req_char_code),
      .req_row        (req_row),
      .req_col        (req_col),
      .cmd            (cmd),
      .status         (status),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_enable_pin (rsp_enable_pin),
      .rsp_select_pin (rsp_select_pin),
      .rsp_data_pins  (rsp_data_pins),
      .rsp_hold_us    (rsp_hold_us),
      .rsp_last       (rsp_last)
   );

   `LCDNS_ASSERT_IMPL(a_last_strobe_low, clock, reset, rsp_valid && rsp_last, !rsp_enable_pin)
   `LCDNS_ASSERT_IMPL(a_strobe_hold, clock, reset, rsp_valid && rsp_enable_pin, rsp_hold_us == 16'd50)
   `LCDNS_ASSERT_NEXT(a_one_cmd_at_a_time, clock, reset, req_valid && req_ready, !req_ready)
   `LCDNS_ASSERT(a_fire_needs_slot, clock, reset, !cmd.fire || status.slot_free)

endmodule
